// ===== rtl/fsmff_pkg.sv =====
package fsmff_pkg;

	localparam int PID_W     = 13;
	localparam int SIZE_W    = 16;
	localparam int FREE_W    = 16;
	localparam int NEED_W    = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_OVERHEAD  = 1'd1;

	localparam logic [15:0] ENTRY_CAPACITY_RST = 16'd4096;
	localparam logic [7:0]  SLOT_OVERHEAD_RST  = 8'd4;

	// Request actions.
	localparam logic ACT_ALLOCATE = 1'b0;
	localparam logic ACT_RELEASE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_FULL        = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE   = 2'd2;
	localparam logic [1:0] ST_BAD_RELEASE = 2'd3;

	typedef struct packed {
		logic              action;
		logic [SIZE_W-1:0] record_size;
		logic [PID_W-1:0]  page_id;
	} req_t;

	typedef struct packed {
		logic [PID_W-1:0] page_id_out;
		logic             new_data_page;
		logic             new_map_page;
		logic [1:0]       status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_req;
		logic       rel_rd;
		logic       rel_wr;
		logic       scan_start;
		logic       scan_step;
		logic       fill_start;
		logic       fill_step;
		logic       set_err;
		logic [1:0] err_code;
		logic       load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_release;
		logic rel_bad;
		logic too_large;
		logic hit;
		logic scan_done;
		logic table_full;
		logic fill_last;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/fsmff_ram.sv =====
module fsmff_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/fsmff_ctrl.sv =====
module fsmff_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fsmff_pkg::sts_t sts,
	output fsmff_pkg::cmd_t cmd
);
	import fsmff_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_REL_RD = 6'b000100,
		S_SCAN   = 6'b001000,
		S_FILL   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_release) begin
					if (sts.rel_bad) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_BAD_RELEASE;
						state_d      = S_DONE;
					end else begin
						cmd.rel_rd = 1'b1;
						state_d    = S_REL_RD;
					end
				end else if (sts.too_large) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_TOO_LARGE;
					state_d      = S_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_REL_RD: begin
				cmd.rel_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.hit) begin
					state_d = S_DONE;
				end else if (sts.scan_done) begin
					if (sts.table_full) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_FULL;
						state_d      = S_DONE;
					end else begin
						cmd.fill_start = 1'b1;
						state_d        = S_FILL;
					end
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/fsmff_dp.sv =====
module fsmff_dp #(
	parameter int ENTRIES_PER_MAP = 256,
	parameter int MAP_PAGES       = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [fsmff_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [fsmff_pkg::CFG_W-1:0]   wr_data,
	input  fsmff_pkg::req_t               req,
	output fsmff_pkg::rsp_t               rsp,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  fsmff_pkg::cmd_t               cmd,
	output fsmff_pkg::sts_t               sts
);
	import fsmff_pkg::*;

	localparam int DEPTH  = ENTRIES_PER_MAP * MAP_PAGES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PAGE_W = $clog2(DEPTH + 1);
	localparam int FILL_W = (ENTRIES_PER_MAP > 1) ? $clog2(ENTRIES_PER_MAP) : 1;
	localparam int CMP_W  = (PAGE_W > PID_W) ? PAGE_W : PID_W;

	logic [15:0]        cap_q;
	logic [7:0]         ovh_q;
	req_t               req_q;
	logic [NEED_W-1:0]  need_q;
	logic [PAGE_W-1:0]  open_limit_q;
	logic [PAGE_W-1:0]  made_q;
	logic [PAGE_W-1:0]  scan_q;
	logic               pend_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [FILL_W-1:0]  fill_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic [FREE_W-1:0]  rd_data;
	logic [ADDR_W-1:0]  raddr;
	logic [ADDR_W-1:0]  waddr;
	logic [FREE_W-1:0]  wdata;
	logic               we;
	logic               hit;
	logic               issue;
	logic               fill_last;
	logic [PID_W-1:0]   pid_m1;
	logic [CMP_W-1:0]   pid_ext;
	logic [CMP_W-1:0]   made_ext;
	logic [17:0]        rel_sum;
	logic [FREE_W-1:0]  rel_sat;
	logic [PAGE_W-1:0]  fill_page;
	logic [PAGE_W-1:0]  chosen;
	logic               fresh;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ENTRY_CAPACITY_RST;
			ovh_q <= SLOT_OVERHEAD_RST;
		end else if (wr_en) begin
			if (wr_index == CFG_ENTRY_CAPACITY) begin
				cap_q <= wr_data;
			end else if (wr_index == CFG_SLOT_OVERHEAD) begin
				ovh_q <= wr_data[7:0];
			end
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q  <= req;
			need_q <= {1'b0, req.record_size} + NEED_W'(ovh_q);
		end
	end

	assign pid_m1   = req_q.page_id - PID_W'(1);
	assign pid_ext  = CMP_W'(req_q.page_id);
	assign made_ext = CMP_W'(made_q);
	assign rel_sum  = {2'b00, rd_data} + {1'b0, need_q};
	assign rel_sat  = (rel_sum > {2'b00, cap_q}) ? cap_q : rel_sum[15:0];

	assign hit       = pend_s1 && ({1'b0, rd_data} >= need_q);
	assign issue     = scan_q < open_limit_q;
	assign fill_last = (fill_q == FILL_W'(ENTRIES_PER_MAP - 1));
	assign fill_page = open_limit_q + PAGE_W'(fill_q);

	assign chosen = cmd.fill_step ? (open_limit_q + PAGE_W'(1))
	                              : (PAGE_W'(addr_s1) + PAGE_W'(1));
	assign fresh  = chosen > made_q;

	assign raddr = cmd.rel_rd ? ADDR_W'(pid_m1) : ADDR_W'(scan_q);

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rd_data - need_q[15:0];
		if (cmd.rel_wr) begin
			we    = 1'b1;
			waddr = ADDR_W'(pid_m1);
			wdata = rel_sat;
		end else if (cmd.scan_step && hit) begin
			we = 1'b1;
		end else if (cmd.fill_step) begin
			we    = 1'b1;
			waddr = ADDR_W'(fill_page);
			wdata = (fill_q == '0) ? (cap_q - need_q[15:0]) : cap_q;
		end
	end

	fsmff_ram #(
		.WIDTH (FREE_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// Scan pointer and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			pend_s1 <= 1'b0;
		end else if (cmd.scan_step) begin
			pend_s1 <= issue && !hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_q <= '0;
		end else if (cmd.scan_step && issue && !hit) begin
			scan_q  <= scan_q + PAGE_W'(1);
			addr_s1 <= ADDR_W'(scan_q);
		end
		if (cmd.fill_start) begin
			fill_q <= '0;
		end else if (cmd.fill_step) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	// Open map pages and highest data page made.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_limit_q <= '0;
			made_q       <= '0;
		end else begin
			if (cmd.fill_step && fill_last) begin
				open_limit_q <= open_limit_q + PAGE_W'(ENTRIES_PER_MAP);
			end
			if (((cmd.scan_step && hit) || (cmd.fill_step && fill_last)) && fresh) begin
				made_q <= chosen;
			end
		end
	end

	// Result assembly.
	always_ff @(posedge clk) begin
		if (cmd.set_err) begin
			res_q <= '{page_id_out: '0, new_data_page: 1'b0, new_map_page: 1'b0,
			           status: cmd.err_code};
		end else if (cmd.rel_wr) begin
			res_q <= '{page_id_out: req_q.page_id, new_data_page: 1'b0,
			           new_map_page: 1'b0, status: ST_OK};
		end else if ((cmd.scan_step && hit) || (cmd.fill_step && fill_last)) begin
			res_q <= '{page_id_out: PID_W'(chosen), new_data_page: fresh,
			           new_map_page: cmd.fill_step, status: ST_OK};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign sts.is_release = (req_q.action == ACT_RELEASE);
	assign sts.rel_bad    = (req_q.page_id == '0) || (pid_ext > made_ext);
	assign sts.too_large  = need_q > {1'b0, cap_q};
	assign sts.hit        = hit;
	assign sts.scan_done  = !pend_s1 && !issue;
	assign sts.table_full = (open_limit_q == PAGE_W'(DEPTH));
	assign sts.fill_last  = fill_last;
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		open_limit_q <= PAGE_W'(DEPTH))
		else $error("open map pages exceed the table");

	assert property (@(posedge clk) disable iff (!arst_n)
		made_q <= open_limit_q)
		else $error("a data page lies beyond the open map pages");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.rel_wr, cmd.scan_step && hit, cmd.fill_step}))
		else $error("two table writes requested at once");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !rsp_valid_q || rsp_ready)
		else $error("result beat overwritten before it was taken");

endmodule

// ===== rtl/free_space_map_first_fit.sv =====
// A rejected request goes from decode straight to the result; a release first does a read-modify-write.
// An allocation scans the entries before a fit, one per cycle through the table RAM read port,
// and sweeps the ENTRIES_PER_MAP entries of a new map page when one is opened.
// The block takes one request at a time; the next is taken only once the result is loaded.
// Reset clears the open map page count and the data page count; the table needs no clearing.
module free_space_map_first_fit #(
	parameter int ENTRIES_PER_MAP = 256,
	parameter int MAP_PAGES       = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [fsmff_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [fsmff_pkg::CFG_W-1:0]   wr_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  fsmff_pkg::req_t               req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output fsmff_pkg::rsp_t               rsp
);
	import fsmff_pkg::*;

	// The controller sequences each request: decode, which may refuse it, then either a read-modify-write of one
	// table entry for a release, or a first-fit scan over the open map pages followed, when
	// nothing fits and a map page is left, by a sweep that fills a fresh map page with the page capacity.
	cmd_t cmd;
	sts_t sts;

	fsmff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the free-byte table, the scan pipeline and the result and output registers. The
	// output register parts the two sides, so a finished beat may wait while the next
	// request is already taken in.
	fsmff_dp #(
		.ENTRIES_PER_MAP(ENTRIES_PER_MAP),
		.MAP_PAGES      (MAP_PAGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ===== tb/sv/tb_free_space_map_first_fit.sv =====
module tb_free_space_map_first_fit;
	import fsmff_pkg::*;

	// The block is built with its default geometry: 16 map pages of 256 entries.
	localparam int ENTRIES = 256;
	localparam int MAPS    = 16;
	localparam int DEPTH   = ENTRIES * MAPS;

	localparam int CAP_MAX = 65535;
	localparam int OVH_MAX = 255;

	// The slowest request is an allocation that scans fifteen open map pages and then fills
	// the last one. Even if every one of the ~600 requests were that slow and each result
	// also waited out a long receiver stall, the run would stay well inside this bound.
	localparam int CYCLE_LIMIT = 20000000;

	// The quiet time allowed once nothing is due any more, so that a stray late result is caught.
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		int pid;
		int size;
	} placed_record_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;

	// Our own copy of the free-space table, its counters and both registers. The table is only
	// ever read in entries whose map page has been opened, so it needs no initial value.
	logic [FREE_W-1:0] free_tab [DEPTH];
	int                maps_open = 0;
	int                pages_made = 0;
	int                cap_val = int'(ENTRY_CAPACITY_RST);
	int                ovh_val = int'(SLOT_OVERHEAD_RST);

	// Results still owed by the block, oldest first, and the records currently placed in pages,
	// which give the random traffic well-formed releases to send back.
	rsp_t           due_results [$];
	placed_record_t placed_records [$];

	int   snd_idle_pct = 9;
	int   rcv_idle_pct = 48;
	int   mismatches = 0;
	int   requests_sent = 0;
	int   cycle_count = 0;
	int   status_seen [4] = '{0, 0, 0, 0};
	rsp_t want;

	free_space_map_first_fit #(
		.ENTRIES_PER_MAP(ENTRIES),
		.MAP_PAGES(MAPS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the result of one request and moves our copy of the table on by it. An
	// allocation charges the record plus its slot to the first entry with room, in page order
	// over the open map pages; failing that it opens the next map page, if one is left, at full capacity and
	// charges its first entry. A release credits the entry back, never above the capacity.
	function automatic rsp_t update_free_space(input req_t r);
		rsp_t res;
		int   need;
		int   pid;
		int   sum;
		int   hit;
		int   base;
		res  = '0;
		need = int'(r.record_size) + ovh_val;
		pid  = int'(r.page_id);
		if (r.action == ACT_RELEASE) begin
			// Page zero, a page never handed out, or one beyond the table is refused.
			if (pid == 0 || pid > pages_made || pid > DEPTH) begin
				res.status = ST_BAD_RELEASE;
			end else begin
				sum = int'(free_tab[pid-1]) + need;
				if (sum > cap_val)
					sum = cap_val;
				free_tab[pid-1] = FREE_W'(sum);
				res.page_id_out = PID_W'(pid);
				res.status = ST_OK;
			end
			return res;
		end
		if (need > cap_val) begin
			res.status = ST_TOO_LARGE;
			return res;
		end
		hit = 0;
		for (int i = 0; i < maps_open * ENTRIES; i++) begin
			if (int'(free_tab[i]) >= need) begin
				free_tab[i] = FREE_W'(int'(free_tab[i]) - need);
				hit = i + 1;
				break;
			end
		end
		if (hit == 0) begin
			// Nothing fits anywhere; with every map page already open the table is full.
			if (maps_open >= MAPS) begin
				res.status = ST_FULL;
				return res;
			end
			base = maps_open * ENTRIES;
			for (int i = 0; i < ENTRIES; i++)
				free_tab[base+i] = FREE_W'(cap_val);
			free_tab[base] = FREE_W'(cap_val - need);
			maps_open++;
			hit = base + 1;
			res.new_map_page = 1'b1;
		end
		if (hit > pages_made) begin
			pages_made = hit;
			res.new_data_page = 1'b1;
		end
		res.page_id_out = PID_W'(hit);
		res.status = ST_OK;
		return res;
	endfunction

	function automatic void note_mismatch(input string what, input rsp_t want_r,
			input rsp_t got_r);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: want page %0d new_data %0d new_map %0d status %0d, %s %0d %s %0d %s %0d %s %0d",
				what, want_r.page_id_out, want_r.new_data_page, want_r.new_map_page,
				want_r.status, "got page", got_r.page_id_out, "new_data",
				got_r.new_data_page, "new_map", got_r.new_map_page, "status", got_r.status);
	endfunction

	// Sends one request beat. Before raising valid the sender may sit idle at random;
	// once valid is up it stays up, payload unchanged, until the block takes the beat. The
	// result is predicted at the very edge that accepts the beat and queued as due.
	task automatic offer_request(input logic act, input int size, input int pid,
			output rsp_t outcome);
		req_t item;
		item.action      = act;
		item.record_size = SIZE_W'(size);
		item.page_id     = PID_W'(pid);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (!req_ready);
		outcome = update_free_space(item);
		due_results.push_back(outcome);
		requests_sent++;
	endtask

	// Drops valid at the next falling edge, so that the last beat is not taken twice, and then
	// waits until every due result has come back.
	task automatic wait_for_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// A single-cycle register write. Callers only come here with nothing due, so the block is
	// idle and our copy of the register can change at once.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CFG_W'(value);
		if (idx == CFG_ENTRY_CAPACITY)
			cap_val = value & 16'hFFFF;
		else
			ovh_val = value & 8'hFF;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Straight after reset, with the reset values of both registers: refused releases before any
	// page exists, the first map page opening, an exact fit, oversize records and saturation.
	task automatic test_reset_defaults();
		rsp_t got;
		offer_request(ACT_RELEASE, 0, 1, got);      // no data page exists yet
		offer_request(ACT_RELEASE, 0, 0, got);      // page zero is never valid
		offer_request(ACT_ALLOCATE, 0, 0, got);     // opens the first map page, page 1
		offer_request(ACT_ALLOCATE, 100, 8191, got);// page field is ignored on allocate
		offer_request(ACT_ALLOCATE, 4092, 0, got);  // needs a whole empty page: page 2
		offer_request(ACT_ALLOCATE, 4093, 0, got);  // one byte over the capacity
		offer_request(ACT_ALLOCATE, 65535, 0, got); // largest record size
		offer_request(ACT_RELEASE, 4092, 2, got);   // page 2 back to exactly full capacity
		offer_request(ACT_RELEASE, 65535, 1, got);  // credit far beyond capacity saturates
		offer_request(ACT_RELEASE, 10, 3, got);     // just past the last page handed out
		offer_request(ACT_RELEASE, 10, 8191, got);  // every page bit set
		offer_request(ACT_RELEASE, 10, 4096, got);  // last table page, never handed out
		offer_request(ACT_ALLOCATE, 3000, 0, got);
		wait_for_results();
	endtask

	// The register extremes: a capacity of one byte with no slot overhead, then the largest
	// overhead. Lowering the capacity also makes releases pull entries down to it.
	task automatic test_register_extremes();
		rsp_t got;
		write_register(CFG_ENTRY_CAPACITY, 1);
		write_register(CFG_SLOT_OVERHEAD, 0);
		offer_request(ACT_ALLOCATE, 0, 0, got);
		offer_request(ACT_ALLOCATE, 1, 0, got);
		offer_request(ACT_ALLOCATE, 2, 0, got);
		offer_request(ACT_RELEASE, 0, 1, got);
		offer_request(ACT_RELEASE, 1, 2, got);
		wait_for_results();
		write_register(CFG_ENTRY_CAPACITY, 4096);
		write_register(CFG_SLOT_OVERHEAD, OVH_MAX);
		offer_request(ACT_ALLOCATE, 4096 - OVH_MAX, 0, got);
		offer_request(ACT_ALLOCATE, 4096 - OVH_MAX + 1, 0, got);
		offer_request(ACT_RELEASE, 4096 - OVH_MAX, 1, got);
		wait_for_results();
	endtask

	// Mostly well-formed traffic: allocations of modest records, now and then one that needs a
	// whole empty page, and releases of records placed earlier with their true sizes. The rest
	// is noise over the full range of every field, which mostly ends as refusals.
	task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int cap,
			input int ovh, input int count);
		placed_record_t rec;
		rsp_t           got;
		int             roll;
		int             size;
		int             pick;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		write_register(CFG_ENTRY_CAPACITY, cap);
		write_register(CFG_SLOT_OVERHEAD, ovh);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 55) begin
				if ($urandom_range(19) == 0)
					size = cap - ovh;
				else
					size = $urandom_range(cap / 5);
				offer_request(ACT_ALLOCATE, size, $urandom_range(8191), got);
				if (got.status == ST_OK) begin
					rec.pid  = int'(got.page_id_out);
					rec.size = size;
					placed_records.push_back(rec);
				end
			end else if (roll < 85 && placed_records.size() > 0) begin
				pick = $urandom_range(placed_records.size() - 1);
				rec  = placed_records[pick];
				placed_records.delete(pick);
				offer_request(ACT_RELEASE, rec.size, rec.pid, got);
			end else begin
				offer_request(($urandom_range(1) == 1) ? ACT_RELEASE : ACT_ALLOCATE,
					$urandom_range(65535), $urandom_range(8191), got);
			end
		end
		wait_for_results();
	endtask

	// Opens every remaining map page cheaply: before each allocation the capacity is raised
	// above anything the table holds, so the request fits nowhere and a fresh map page is
	// opened at the new capacity. With all pages open a request at the largest capacity finds
	// the table full. A last fit lands in the newest map page, at the far end of the scan.
	task automatic test_fill_table();
		rsp_t got;
		int   steps;
		int   step_cap;
		int   page;
		step_cap = 8192;
		write_register(CFG_SLOT_OVERHEAD, OVH_MAX);
		steps = MAPS - maps_open;
		for (int k = 1; k <= steps; k++) begin
			step_cap = 8192 + (k * (65000 - 8192)) / steps;
			write_register(CFG_ENTRY_CAPACITY, step_cap);
			offer_request(ACT_ALLOCATE, step_cap - OVH_MAX, 0, got);
			wait_for_results();
		end
		write_register(CFG_ENTRY_CAPACITY, CAP_MAX);
		offer_request(ACT_ALLOCATE, CAP_MAX - OVH_MAX, 0, got);
		offer_request(ACT_ALLOCATE, CAP_MAX, 0, got);
		offer_request(ACT_ALLOCATE, step_cap - OVH_MAX, 0, got);
		page = int'(got.page_id_out);
		offer_request(ACT_RELEASE, 0, (page == 0) ? 1 : page, got);
		offer_request(ACT_RELEASE, 1, pages_made + 1, got);
		offer_request(ACT_ALLOCATE, 0, 0, got);
		wait_for_results();
	endtask

	// The receiver is ready at random, changing only on falling edges.
	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);

	// Every result beat is matched against the oldest result still due, field by field.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (due_results.size() == 0) begin
				note_mismatch("result with nothing due", '0, rsp);
			end else begin
				want = due_results.pop_front();
				if (rsp.page_id_out !== want.page_id_out ||
						rsp.new_data_page !== want.new_data_page ||
						rsp.new_map_page !== want.new_map_page ||
						rsp.status !== want.status)
					note_mismatch("result differs", want, rsp);
			end
			status_seen[rsp.status]++;
		end
	end

	// A hung handshake must not stall the run for ever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d results due", cycle_count,
				due_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		wr_en     = 1'b0;
		wr_index  = CFG_ENTRY_CAPACITY;
		wr_data   = '0;
		req_valid = 1'b0;
		req       = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The first phases run with a sender that rarely idles and a receiver that often stalls.
		test_reset_defaults();
		test_register_extremes();
		test_random_traffic(9, 48, 4096, 0, 185);
		test_random_traffic(48, 9, 2048, OVH_MAX, 185);
		test_random_traffic(0, 0, 3000, 17, 185);
		test_fill_table();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: both actions, three idling mixes, %s %0d, %s %0d",
			requests_sent, "capacity 1 to", CAP_MAX, "overhead 0 to", OVH_MAX);
		$display("statuses seen: %0d ok, %0d table full, %0d too large, %0d bad release; %s %0d",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_TOO_LARGE],
			status_seen[ST_BAD_RELEASE], "map pages open", maps_open);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fsmff_pkg.sv
rtl/fsmff_ram.sv
rtl/fsmff_ctrl.sv
rtl/fsmff_dp.sv
rtl/free_space_map_first_fit.sv
tb/sv/tb_free_space_map_first_fit.sv
